// ===== rtl/mi3_pkg.sv =====
package mi3_pkg;

	localparam int WORD_BITS     = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int THR_BITS      = 31;
	localparam int ADJW          = 2 * WORD_BITS + 1;
	localparam int AABSW         = 2 * WORD_BITS;
	localparam int DETW          = 3 * WORD_BITS + 3;
	localparam int DABSW         = 3 * WORD_BITS + 2;
	localparam int Q_DEPTH       = 4;

	// cofactor entry i = m[A]*m[B] - m[C]*m[D]
	localparam int unsigned ADJ_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int unsigned ADJ_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int unsigned ADJ_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int unsigned ADJ_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	typedef struct packed {
		logic signed [WORD_BITS-1:0] in_r0c0;
		logic signed [WORD_BITS-1:0] in_r0c1;
		logic signed [WORD_BITS-1:0] in_r0c2;
		logic signed [WORD_BITS-1:0] in_r1c0;
		logic signed [WORD_BITS-1:0] in_r1c1;
		logic signed [WORD_BITS-1:0] in_r1c2;
		logic signed [WORD_BITS-1:0] in_r2c0;
		logic signed [WORD_BITS-1:0] in_r2c1;
		logic signed [WORD_BITS-1:0] in_r2c2;
	} matrix_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] out_r0c0;
		logic signed [WORD_BITS-1:0] out_r0c1;
		logic signed [WORD_BITS-1:0] out_r0c2;
		logic signed [WORD_BITS-1:0] out_r1c0;
		logic signed [WORD_BITS-1:0] out_r1c1;
		logic signed [WORD_BITS-1:0] out_r1c2;
		logic signed [WORD_BITS-1:0] out_r2c0;
		logic signed [WORD_BITS-1:0] out_r2c1;
		logic signed [WORD_BITS-1:0] out_r2c2;
		logic                        singular_flag;
		logic                        saturated_flag;
	} result_t;

	typedef struct packed {
		logic                        singular;
		logic [8:0]                  neg;
		logic [DABSW-1:0]            dabs;
		logic [8:0][AABSW-1:0]       adj_abs;
	} entry_t;

endpackage

// ===== rtl/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse in signed fixed point. A matrix is taken when start is high and busy low;
// the front pipeline forms cofactors and the exact determinant, then parks the item in a
// four-entry queue. The back end divides all nine cofactors at once with one restoring
// divider per entry, one quotient bit per cycle, and takes the next item only once it has
// finished the last one; singular items skip the divider. Results appear for exactly one
// cycle with done and cannot be held off, so capture them when done is high.
module matrix_inverse_3x3 #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         thr_we,
	input  logic [mi3_pkg::THR_BITS-1:0] thr_data,
	input  logic                         start,
	input  mi3_pkg::matrix_t             matrix,
	output logic                         busy,
	output logic                         done,
	output mi3_pkg::result_t             result
);
	localparam int CNTW = $clog2(mi3_pkg::Q_DEPTH + 1);

	logic [mi3_pkg::THR_BITS-1:0] thr_q;
	logic                         accept, push, pop, empty;
	logic [2:0]                   inflight;
	logic [CNTW-1:0]              count;
	mi3_pkg::entry_t              push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= mi3_pkg::THR_BITS'(1);
		else if (thr_we) thr_q <= thr_data;
	end

	assign busy   = (5'(count) + 5'(inflight)) >= 5'(mi3_pkg::Q_DEPTH);
	assign accept = start && !busy;

	mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.matrix   (matrix),
		.thr      (thr_q),
		.push     (push),
		.entry    (push_data),
		.inflight (inflight)
	);

	mi3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.count     (count),
		.empty     (empty)
	);

	mi3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.entry  (pop_data),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

// ===== rtl/mi3_front.sv =====
module mi3_front #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  mi3_pkg::matrix_t              matrix,
	input  logic [mi3_pkg::THR_BITS-1:0]  thr,
	output logic                          push,
	output mi3_pkg::entry_t               entry,
	output logic [2:0]                    inflight
);
	localparam int W     = mi3_pkg::WORD_BITS;
	localparam int ADJW  = mi3_pkg::ADJW;
	localparam int AABSW = mi3_pkg::AABSW;
	localparam int DETW  = mi3_pkg::DETW;
	localparam int DABSW = mi3_pkg::DABSW;
	localparam int PPW   = 2 * W + 1;

	logic signed [W-1:0]    m [9];
	logic                   v_s1, v_s2, v_s3, v_s4;
	logic signed [2*W-1:0]  pa_s1 [9];
	logic signed [2*W-1:0]  pb_s1 [9];
	logic signed [W-1:0]    row_s1 [3];
	logic signed [ADJW-1:0] adj_s2 [9];
	logic signed [W-1:0]    row_s2 [3];
	logic signed [PPW-1:0]  pl_s3 [3];
	logic signed [PPW-1:0]  ph_s3 [3];
	logic signed [ADJW-1:0] adj_s3 [9];
	logic signed [ADJW-1:0] adj_s4 [9];
	logic signed [DETW-1:0] det_s4;
	logic [DETW-1:0]        det_abs;
	logic [ADJW-1:0]        adj_abs [9];
	logic [DABSW-1:0]       thr_sh;

	assign m[0] = matrix.in_r0c0;
	assign m[1] = matrix.in_r0c1;
	assign m[2] = matrix.in_r0c2;
	assign m[3] = matrix.in_r1c0;
	assign m[4] = matrix.in_r1c1;
	assign m[5] = matrix.in_r1c2;
	assign m[6] = matrix.in_r2c0;
	assign m[7] = matrix.in_r2c1;
	assign m[8] = matrix.in_r2c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			pa_s1[i]  <= m[mi3_pkg::ADJ_A[i]] * m[mi3_pkg::ADJ_B[i]];
			pb_s1[i]  <= m[mi3_pkg::ADJ_C[i]] * m[mi3_pkg::ADJ_D[i]];
			adj_s2[i] <= ADJW'(pa_s1[i]) - ADJW'(pb_s1[i]);
			adj_s3[i] <= adj_s2[i];
			adj_s4[i] <= adj_s3[i];
		end
		for (int k = 0; k < 3; k++) begin
			row_s1[k] <= m[k];
			row_s2[k] <= row_s1[k];
			pl_s3[k]  <= row_s2[k] * $signed({1'b0, adj_s2[3*k][W-1:0]});
			ph_s3[k]  <= row_s2[k] * $signed(adj_s2[3*k][ADJW-1:W]);
		end
		det_s4 <= (DETW'(ph_s3[0]) <<< W) + DETW'(pl_s3[0])
			+ (DETW'(ph_s3[1]) <<< W) + DETW'(pl_s3[1])
			+ (DETW'(ph_s3[2]) <<< W) + DETW'(pl_s3[2]);
	end

	// classify and hand over to the queue
	always_comb begin
		det_abs = det_s4[DETW-1] ? DETW'(-det_s4) : DETW'(det_s4);
		thr_sh  = DABSW'(thr) << (2 * FRAC_BITS);
		for (int i = 0; i < 9; i++) begin
			adj_abs[i]         = adj_s4[i][ADJW-1] ? ADJW'(-adj_s4[i]) : ADJW'(adj_s4[i]);
			entry.adj_abs[i]   = adj_abs[i][AABSW-1:0];
			entry.neg[i]       = adj_s4[i][ADJW-1] ^ det_s4[DETW-1];
		end
		entry.dabs     = det_abs[DABSW-1:0];
		entry.singular = (entry.dabs == '0) || (entry.dabs < thr_sh);
	end

	assign push     = v_s4;
	assign inflight = {2'b00, v_s1} + {2'b00, v_s2} + {2'b00, v_s3} + {2'b00, v_s4};

endmodule

// ===== rtl/mi3_queue.sv =====
module mi3_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  mi3_pkg::entry_t                   push_data,
	input  logic                              pop,
	output mi3_pkg::entry_t                   pop_data,
	output logic [$clog2(mi3_pkg::Q_DEPTH+1)-1:0] count,
	output logic                              empty
);
	localparam int PTRW = $clog2(mi3_pkg::Q_DEPTH);
	localparam int CNTW = $clog2(mi3_pkg::Q_DEPTH + 1);

	mi3_pkg::entry_t  mem_q [mi3_pkg::Q_DEPTH];
	logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTRW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTRW'(1);
			if (push && !pop) count_q <= count_q + CNTW'(1);
			else if (pop && !push) count_q <= count_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	assign pop_data = mem_q[rd_ptr_q];
	assign count    = count_q;
	assign empty    = (count_q == '0);

endmodule

// ===== rtl/mi3_back.sv =====
module mi3_back #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  mi3_pkg::entry_t entry,
	output logic            pop,
	output logic            done,
	output mi3_pkg::result_t result
);
	localparam int W     = mi3_pkg::WORD_BITS;
	localparam int RW    = 2 * W + 2 * FRAC_BITS;
	localparam int DSW   = mi3_pkg::DABSW + W;
	localparam int SCW   = $clog2(W + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t           state_q;
	logic [SCW-1:0]   step_q;
	logic             done_q;
	logic [RW-1:0]    rem_q [9];
	logic [W:0]       quo_q [9];
	logic [DSW-1:0]   dsh_q;
	logic [8:0]       neg_q;
	logic [W-1:0]     res_q [9];
	logic             sing_q, sat_q;
	logic [8:0]       ge;
	logic [RW-1:0]    rem_nx [9];
	logic [8:0]       ovf;
	logic [W-1:0]     fin [9];
	logic [W-1:0]     one_w;

	assign one_w = W'(1) << FRAC_BITS;
	assign pop   = (state_q == S_IDLE) && !empty;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			ge[i]     = DSW'(rem_q[i]) >= dsh_q;
			rem_nx[i] = RW'(DSW'(rem_q[i]) - dsh_q);
			ovf[i]    = quo_q[i][W] || (quo_q[i][W-1] && (!neg_q[i] || (|quo_q[i][W-2:0])));
			if (ovf[i]) fin[i] = neg_q[i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			else fin[i] = neg_q[i] ? W'(0) - quo_q[i][W-1:0] : quo_q[i][W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						if (entry.singular) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_DIV;
							step_q  <= SCW'(W);
						end
					end
				end
				S_DIV: begin
					if (step_q == '0) state_q <= S_FIN;
					else step_q <= step_q - SCW'(1);
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (!empty) begin
					dsh_q <= DSW'(entry.dabs) << W;
					neg_q <= entry.neg;
					for (int i = 0; i < 9; i++) begin
						rem_q[i] <= RW'(entry.adj_abs[i]) << (2 * FRAC_BITS);
						quo_q[i] <= '0;
					end
					if (entry.singular) begin
						for (int i = 0; i < 9; i++) res_q[i] <= (i % 4 == 0) ? one_w : '0;
						sing_q <= 1'b1;
						sat_q  <= 1'b0;
					end
				end
			end
			S_DIV: begin
				dsh_q <= dsh_q >> 1;
				for (int i = 0; i < 9; i++) begin
					quo_q[i] <= {quo_q[i][W-1:0], ge[i]};
					if (ge[i]) rem_q[i] <= rem_nx[i];
				end
			end
			S_FIN: begin
				for (int i = 0; i < 9; i++) res_q[i] <= fin[i];
				sing_q <= 1'b0;
				sat_q  <= |ovf;
			end
			default: ;
		endcase
	end

	assign done                  = done_q;
	assign result.out_r0c0       = res_q[0];
	assign result.out_r0c1       = res_q[1];
	assign result.out_r0c2       = res_q[2];
	assign result.out_r1c0       = res_q[3];
	assign result.out_r1c1       = res_q[4];
	assign result.out_r1c2       = res_q[5];
	assign result.out_r2c0       = res_q[6];
	assign result.out_r2c1       = res_q[7];
	assign result.out_r2c2       = res_q[8];
	assign result.singular_flag  = sing_q;
	assign result.saturated_flag = sat_q;

endmodule

// ===== rtl/mi3_checker.sv =====
module mi3_checker #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input mi3_pkg::result_t result
);
	localparam int W = mi3_pkg::WORD_BITS;

	logic [3:0] out_q;
	logic       acc;

	assign acc = start && !busy;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_q <= '0;
		else out_q <= out_q + {3'b000, acc} - {3'b000, done};
	end

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_q != '0)
		else $error("item delivered that was never taken");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_q <= 4'(mi3_pkg::Q_DEPTH + 2))
		else $error("more items outstanding than the block can hold");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.singular_flag |-> !result.saturated_flag
			&& result.out_r0c0 == (W'(1) << FRAC_BITS)
			&& result.out_r1c1 == (W'(1) << FRAC_BITS)
			&& result.out_r2c2 == (W'(1) << FRAC_BITS)
			&& result.out_r0c1 == '0 && result.out_r0c2 == '0
			&& result.out_r1c0 == '0 && result.out_r1c2 == '0
			&& result.out_r2c0 == '0 && result.out_r2c1 == '0)
		else $error("singular item without the identity");

endmodule

bind matrix_inverse_3x3 mi3_checker #(.FRAC_BITS(FRAC_BITS)) u_mi3_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== sim/matrix_inverse_3x3_tb.sv =====
`timescale 1ns / 1ps

module matrix_inverse_3x3_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int ONE = 1 << 16;
	localparam int WORD_BITS = mi3_pkg::WORD_BITS;
	localparam int THR_BITS = mi3_pkg::THR_BITS;
	localparam int FRAC_BITS_DEF = mi3_pkg::FRAC_BITS_DEF;

	logic                clk;
	logic                arst_n;
	logic                thr_we;
	logic [THR_BITS-1:0] thr_data;
	logic                start;
	mi3_pkg::matrix_t    matrix;
	logic                busy;
	logic                done;
	mi3_pkg::result_t    result;

	logic [THR_BITS-1:0] threshold;
	mi3_pkg::result_t    pending_inverses[$];
	int                  mismatches;
	int                  stall_cycles;
	int                  idle_pct;

	matrix_inverse_3x3 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.thr_we   (thr_we),
		.thr_data (thr_data),
		.start    (start),
		.matrix   (matrix),
		.busy     (busy),
		.done     (done),
		.result   (result)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic mi3_pkg::result_t predict_inverse(mi3_pkg::matrix_t mx,
			logic [THR_BITS-1:0] thr);
		logic signed [127:0] e [9];
		logic signed [127:0] cof [9];
		logic signed [127:0] det;
		logic [127:0] dabs;
		logic [127:0] num;
		logic [127:0] quo;
		logic [127:0] lim;
		logic [127:0] thr_scaled;
		logic signed [127:0] val;
		logic [9*WORD_BITS+1:0] bits;
		logic neg;
		logic sat;
		mi3_pkg::result_t r;
		bits = mx;
		for (int i = 0; i < 9; i++)
			e[i] = 128'(signed'(bits[WORD_BITS*(8-i) +: WORD_BITS]));
		for (int i = 0; i < 9; i++)
			cof[i] = e[mi3_pkg::ADJ_A[i]] * e[mi3_pkg::ADJ_B[i]]
				- e[mi3_pkg::ADJ_C[i]] * e[mi3_pkg::ADJ_D[i]];
		det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
		dabs = det < 0 ? -det : det;
		thr_scaled = 128'(thr) << (2 * FRAC_BITS_DEF);
		bits = '0;
		if (det == 0 || dabs < thr_scaled) begin
			for (int i = 0; i < 9; i++)
				bits[2 + WORD_BITS*(8-i) +: WORD_BITS] = (i % 4 == 0) ? ONE : 0;
			bits[1] = 1'b1;
			return mi3_pkg::result_t'(bits);
		end
		sat = 1'b0;
		for (int i = 0; i < 9; i++) begin
			num = cof[i] < 0 ? -cof[i] : cof[i];
			num = num << (2 * FRAC_BITS_DEF);
			quo = num / dabs;
			neg = (cof[i] < 0) != (det < 0);
			lim = neg ? (128'd1 << (WORD_BITS-1)) : ((128'd1 << (WORD_BITS-1)) - 1);
			if (quo > lim) begin
				sat = 1'b1;
				quo = lim;
			end
			val = neg ? -$signed(quo) : $signed(quo);
			bits[2 + WORD_BITS*(8-i) +: WORD_BITS] = val[WORD_BITS-1:0];
		end
		bits[0] = sat;
		r = mi3_pkg::result_t'(bits);
		return r;
	endfunction

	// result checking and watchdog, sampled mid-cycle
	always @(negedge clk) begin
		mi3_pkg::result_t want;
		logic [9*WORD_BITS+1:0] wb;
		logic [9*WORD_BITS+1:0] gb;
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired");
				$display("Verification failed");
				$finish;
			end
		end
		if (arst_n && done) begin
			if (pending_inverses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				want = pending_inverses.pop_front();
				wb = want;
				gb = result;
				for (int i = 0; i < 9; i++)
					if (wb[2 + WORD_BITS*(8-i) +: WORD_BITS] !==
							gb[2 + WORD_BITS*(8-i) +: WORD_BITS]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("r%0dc%0d: expected %h got %h", i / 3, i % 3,
								wb[2 + WORD_BITS*(8-i) +: WORD_BITS],
								gb[2 + WORD_BITS*(8-i) +: WORD_BITS]);
					end
				if (want.singular_flag !== result.singular_flag) begin
					mismatches++;
					if (mismatches <= 10)
						$display("singular_flag: expected %b got %b",
							want.singular_flag, result.singular_flag);
				end
				if (want.saturated_flag !== result.saturated_flag) begin
					mismatches++;
					if (mismatches <= 10)
						$display("saturated_flag: expected %b got %b",
							want.saturated_flag, result.saturated_flag);
				end
			end
		end
	end

	task automatic send_matrix(mi3_pkg::matrix_t mx);
		int gap;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		matrix <= mx;
		do @(negedge clk); while (busy);
		@(posedge clk);
		pending_inverses.push_back(predict_inverse(mx, threshold));
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending_inverses.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_BITS-1:0] v);
		drain();
		thr_we <= 1'b1;
		thr_data <= v;
		@(posedge clk);
		thr_we <= 1'b0;
		threshold = v;
	endtask

	function automatic logic signed [31:0] small_entry();
		return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
	endfunction

	function automatic mi3_pkg::matrix_t make_matrix(int kind);
		logic signed [31:0] v [9];
		for (int i = 0; i < 9; i++)
			v[i] = (kind == 0) ? $signed($urandom()) : small_entry();
		case (kind)
			2: begin
				for (int i = 0; i < 3; i++) v[6+i] = v[$urandom_range(0, 1) * 3 + i];
			end
			3: begin
				for (int i = 0; i < 9; i++)
					if (i % 4 != 0) v[i] = $signed($urandom_range(0, 255)) - 128;
					else v[i] = $signed($urandom_range(1, 2 * ONE)) - ONE;
			end
			4: begin
				for (int i = 0; i < 9; i++) v[i] = $signed($urandom_range(0, 16)) - 8;
			end
			default: ;
		endcase
		return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
	endfunction

	function automatic mi3_pkg::matrix_t diag(logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c);
		return {a, 32'sd0, 32'sd0, 32'sd0, b, 32'sd0, 32'sd0, 32'sd0, c};
	endfunction

	task automatic test_directed;
		logic signed [31:0] mx;
		logic signed [31:0] mn;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		idle_pct = 0;
		send_matrix(diag(ONE, ONE, ONE));
		send_matrix('0);
		send_matrix({9{mx}});
		send_matrix({9{mn}});
		send_matrix(diag(mn, mn, mn));
		send_matrix(diag(mx, mx, mx));
		send_matrix(diag(mx, mn, mx));
		send_matrix(diag(ONE, ONE, -ONE));
		send_matrix(diag(2 * ONE, ONE / 2, -4 * ONE));
		send_matrix(diag(1, 1, 1));
		send_matrix(diag(256, 256, 256));
		send_matrix(diag(ONE / 64, ONE, ONE));
		send_matrix(diag(32'sd2, ONE, -ONE));
		send_matrix({mx, mn, 32'sd0, mn, mx, 32'sd1, 32'sd0, -32'sd1, mx});
		send_matrix({32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, ONE, ONE, 32'sd0, 32'sd0});
		send_matrix({2 * ONE, ONE, ONE, ONE, 3 * ONE, 2 * ONE, ONE, 32'sd0, 32'sd0});
		send_matrix(make_matrix(2));
		send_matrix({32'hffffffff, 32'h55555555, 32'haaaaaaaa, 32'h0, 32'h1,
			32'h12345678, 32'hedcba987, 32'h7fff0000, 32'h8000ffff});
		write_threshold('0);
		send_matrix('0);
		send_matrix(make_matrix(2));
		send_matrix(diag(1, 1, 1));
		drain();
	endtask

	task automatic test_threshold;
		logic [THR_BITS-1:0] settings [5];
		settings = '{31'h7fffffff, 31'h10000, 31'd1, 31'h0, 31'h1};
		for (int s = 0; s < 5; s++) begin
			write_threshold(s == 3 ? 31'($urandom()) : settings[s]);
			for (int n = 0; n < 20; n++) begin
				send_matrix(n % 2 ? diag(ONE, ONE, $signed($urandom_range(0, 2 * ONE))
					- ONE) : make_matrix($urandom_range(0, 4)));
			end
		end
		write_threshold(31'd1);
	endtask

	task automatic test_random(int pct, int count);
		int kind;
		idle_pct = pct;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 9);
			send_matrix(make_matrix(kind < 2 ? 0 : kind < 6 ? 1 : kind < 7 ? 2 :
				kind < 9 ? 3 : 4));
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		thr_we = 1'b0;
		thr_data = '0;
		start = 1'b0;
		matrix = '0;
		threshold = 31'd1;
		mismatches = 0;
		stall_cycles = 0;
		idle_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold();
		test_random(0, 400);
		test_random(59, 400);
		write_threshold(31'h100);
		test_random(12, 400);
		drain();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
